// ===== hw/rtl/ema_covariance_mahalanobis_top_macros.svh =====
// Assertion macros for the anomaly scorer
`ifndef EMA_COVARIANCE_MAHALANOBIS_TOP_MACROS_SVH
`define EMA_COVARIANCE_MAHALANOBIS_TOP_MACROS_SVH
// implication checked on every clock, muted in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hw/rtl/emacm_pkg.sv =====
// Package: types, constants, FSM state encoding and fixed-point multiply for the anomaly scorer
`default_nettype none
package emacm_pkg;
	localparam logic [16:0] ALPHA_RESET = 17'd3276;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic signed [31:0] DET_FLOOR = 32'sd10;
	localparam logic signed [31:0] DET_FLOOR_NEG = -32'sd10;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SCORE,
		ST_LEARN,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic signed [31:0] num;
		logic signed [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [31:0] quo;
	} div_rsp_t;

	// full signed product, floor shift by 16, wrap to 32
	function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
		logic signed [63:0] p;
		begin
			p = $signed(a) * $signed(b);
			qmul = p[47:16];
		end
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/emacm_div.sv =====
// Radix-2 restoring divider: (num << 16) / den, truncating toward zero
`default_nettype none
module emacm_div
	import emacm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	`include "ema_covariance_mahalanobis_top_macros.svh"

	localparam int NB = 48;
	logic [NB-1:0] rem_q;
	logic [NB-1:0] quo_q;
	logic [31:0]   den_q;
	logic          neg_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [NB:0]   trial;
	logic [31:0]   num_abs;
	logic [NB-1:0] res_w;

	always_comb begin
		// magnitude of the most negative value still fits 32 unsigned bits
		num_abs = req.num[31] ? 32'(-req.num) : req.num;
		trial = {1'b0, rem_q[NB-2:0], quo_q[NB-1]} - {17'd0, den_q};
		res_w = neg_q ? NB'(-quo_q) : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= {num_abs, 16'd0};
			den_q <= req.den[31] ? 32'(-req.den) : req.den;
			neg_q <= req.num[31] ^ req.den[31];
		end else if (busy_q) begin
			if (!trial[NB]) begin
				rem_q <= trial[NB-1:0];
				quo_q <= {quo_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[NB-2:0], quo_q[NB-1]};
				quo_q <= {quo_q[NB-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = res_w[31:0];

	`ASSERT_NEXT(a_div_done_ends, clk, arst_n, done_q, !busy_q)
	`ASSERT_IMPL(a_div_no_restart, clk, arst_n, req.start, !busy_q)
	`ASSERT_IMPL(a_div_cnt, clk, arst_n, busy_q, cnt_q != 6'd0)
endmodule
`default_nettype wire

// ===== hw/rtl/ema_covariance_mahalanobis_top.sv =====
// Anomaly scorer: 2-D Mahalanobis distance with EMA mean/covariance update
// Flow: accept, difference, score, then for an update item learn and three divisions
// on one shared divider (inverse terms a, b, c), then hold the result until out_stall is low.
// One item at a time; in_stall is high while an item is in work.
// Async active-low reset: zero mean, identity covariance and inverse, alpha 3276.
`default_nettype none
module ema_covariance_mahalanobis_top
	import emacm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [16:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [31:0] phase,
	input  wire logic [31:0] entropy,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      distance_sq
);
	`include "ema_covariance_mahalanobis_top_macros.svh"

	state_t state_q, state_d;
	logic [16:0] alpha_q;
	logic [31:0] mp_q, me_q, vp_q, cc_q, ve_q, if_q, ic_q, is_q;
	logic [31:0] x0_q, x1_q, d0_q, d1_q, acc_q, t_q, det_q;
	logic        kind_q;
	logic [3:0]  step_q, step_d;
	logic [1:0]  dsel_q, dsel_d;
	logic [31:0] ma, mb, mres;
	div_req_t    dreq;
	div_rsp_t    drsp;

	// one shared multiplier, operands picked by the sequencer step
	assign mres = qmul(ma, mb);

	emacm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		ma = d0_q;
		mb = if_q;
		case (state_q)
			ST_SCORE: begin
				case (step_q)
					4'd0: begin ma = d0_q; mb = if_q; end
					4'd1: begin ma = d1_q; mb = ic_q; end
					4'd2: begin ma = t_q;  mb = d0_q; end
					4'd3: begin ma = d0_q; mb = ic_q; end
					4'd4: begin ma = d1_q; mb = is_q; end
					default: begin ma = t_q; mb = d1_q; end
				endcase
			end
			ST_LEARN: begin
				case (step_q)
					4'd0: begin ma = {15'd0, alpha_q}; mb = d0_q; end
					4'd1: begin ma = {15'd0, alpha_q}; mb = d1_q; end
					4'd2: begin ma = d0_q; mb = x0_q - mp_q; end
					4'd3: begin ma = {15'd0, alpha_q}; mb = t_q - vp_q; end
					4'd4: begin ma = d1_q; mb = x1_q - me_q; end
					4'd5: begin ma = {15'd0, alpha_q}; mb = t_q - ve_q; end
					4'd6: begin ma = d0_q; mb = x1_q - me_q; end
					4'd7: begin ma = {15'd0, alpha_q}; mb = t_q - cc_q; end
					4'd8: begin ma = vp_q; mb = ve_q; end
					default: begin ma = cc_q; mb = cc_q; end
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		dsel_d = dsel_q;
		dreq.start = 1'b0;
		dreq.num = $signed(vp_q);
		dreq.den = $signed(det_q);
		case (dsel_q)
			2'd0: dreq.num = $signed(ve_q);
			2'd1: dreq.num = $signed(32'(-cc_q));
			default: dreq.num = $signed(vp_q);
		endcase
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DIFF;
			ST_DIFF: begin state_d = ST_SCORE; step_d = '0; end
			ST_SCORE: begin
				step_d = step_q + 4'd1;
				if (step_q == 4'd5) begin
					step_d = '0;
					state_d = kind_q ? ST_LEARN : ST_OUT;
				end
			end
			ST_LEARN: begin
				step_d = step_q + 4'd1;
				if (step_q == 4'd10) begin
					step_d = '0;
					dsel_d = 2'd0;
					state_d = ST_DIV_START;
				end
			end
			ST_DIV_START: begin
				dreq.start = 1'b1;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: if (drsp.done) begin
				dsel_d = dsel_q + 2'd1;
				state_d = (dsel_q == 2'd2) ? ST_OUT : ST_DIV_START;
			end
			ST_OUT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			dsel_q <= '0;
			alpha_q <= ALPHA_RESET;
			mp_q <= '0; me_q <= '0;
			vp_q <= Q_ONE; cc_q <= '0; ve_q <= Q_ONE;
			if_q <= Q_ONE; ic_q <= '0; is_q <= Q_ONE;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			dsel_q <= dsel_d;
			if (cfg_we) alpha_q <= cfg_wdata;
			if (state_q == ST_LEARN) begin
				case (step_q)
					4'd0: mp_q <= mp_q + mres;
					4'd1: me_q <= me_q + mres;
					4'd3: vp_q <= vp_q + mres;
					4'd5: ve_q <= ve_q + mres;
					4'd7: cc_q <= cc_q + mres;
					default: ;
				endcase
			end
			if (state_q == ST_DIV_WAIT && drsp.done) begin
				case (dsel_q)
					2'd0: if_q <= drsp.quo;
					2'd1: ic_q <= drsp.quo;
					default: is_q <= drsp.quo;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) begin
				kind_q <= kind; x0_q <= phase; x1_q <= entropy;
			end
			ST_DIFF: begin
				d0_q <= x0_q - mp_q; d1_q <= x1_q - me_q; acc_q <= '0;
			end
			ST_SCORE: begin
				case (step_q)
					4'd0: t_q <= mres;
					4'd1: t_q <= t_q + mres;
					4'd3: t_q <= mres;
					4'd4: t_q <= t_q + mres;
					default: acc_q <= acc_q + mres;
				endcase
			end
			ST_LEARN: begin
				case (step_q)
					4'd2, 4'd4, 4'd6: t_q <= mres;
					4'd8: t_q <= mres;
					4'd9: det_q <= t_q - mres;
					4'd10: begin
						if (!det_q[31] && $signed(det_q) < DET_FLOOR) det_q <= DET_FLOOR;
						if (det_q[31] && $signed(det_q) > DET_FLOOR_NEG)
							det_q <= DET_FLOOR_NEG;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign distance_sq = acc_q;

	`ASSERT_IMPL(a_out_hold, clk, arst_n, out_valid && out_stall, ##1 out_valid)
	`ASSERT_IMPL(a_stall_busy, clk, arst_n, out_valid, in_stall)
	`ASSERT_IMPL(a_div_idle, clk, arst_n, state_q == ST_IDLE, !drsp.busy)
	`ASSERT_NEXT(a_accept, clk, arst_n, in_valid && !in_stall, state_q == ST_DIFF)
endmodule
`default_nettype wire

// ===== sim/ema_covariance_mahalanobis_top_tb.sv =====
// Testbench for the 2-D Mahalanobis anomaly scorer: directed table, then random items
`timescale 1ns / 1ps
`default_nettype none
module ema_covariance_mahalanobis_top_tb
	import emacm_pkg::*;
();

	localparam int RANDOM_ITEMS = 1130;
	localparam longint CYCLE_LIMIT = 2_000_000;
	localparam int DRAIN_CYCLES = 250;
	localparam bit KIND_SCORE = 1'b0;
	localparam bit KIND_UPDATE = 1'b1;

	typedef struct {
		logic        kind;
		logic [31:0] phase;
		logic [31:0] entropy;
		bit          has_known;
		logic [31:0] known;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [16:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [31:0] phase;
	logic [31:0] entropy;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] distance_sq;

	// model copy
	logic [16:0] gain;
	logic [31:0] mu_p, mu_e, var_p, cov_pe, var_e, inv_a, inv_b, inv_c;

	logic [31:0] expected_dist[$];
	int          errors;
	int          items_sent;
	int          results_seen;
	int          updates_sent;
	longint      cycles;
	bit          out_stall_hold;

	ema_covariance_mahalanobis_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .phase(phase),
		.entropy(entropy), .out_valid(out_valid), .out_stall(out_stall),
		.distance_sq(distance_sq)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// product: floor of full product over 2^16, wrapped
	function automatic logic [31:0] fx_mul(logic [31:0] a, logic [31:0] b);
		logic signed [63:0] p;
		p = 64'(signed'(a)) * 64'(signed'(b));
		return p[47:16];
	endfunction

	function automatic logic [31:0] fx_div(logic [31:0] num, logic signed [63:0] den);
		logic signed [63:0] n;
		logic signed [63:0] q;
		n = 64'(signed'(num)) * 64'sd65536;
		q = n / den;
		return q[31:0];
	endfunction

	function automatic logic [31:0] mahal_dist(logic [31:0] x0, logic [31:0] x1);
		logic [31:0] d0, d1, t1, t2;
		d0 = x0 - mu_p;
		d1 = x1 - mu_e;
		t1 = fx_mul(d0, inv_a) + fx_mul(d1, inv_b);
		t2 = fx_mul(d0, inv_b) + fx_mul(d1, inv_c);
		return fx_mul(t1, d0) + fx_mul(t2, d1);
	endfunction

	task automatic learn_sample(logic [31:0] x0, logic [31:0] x1);
		logic [31:0] d0, d1, n0, n1, gain32, det32;
		logic signed [63:0] det;
		gain32 = {15'd0, gain};
		d0 = x0 - mu_p;
		d1 = x1 - mu_e;
		mu_p = mu_p + fx_mul(gain32, d0);
		mu_e = mu_e + fx_mul(gain32, d1);
		n0 = x0 - mu_p;
		n1 = x1 - mu_e;
		var_p = var_p + fx_mul(gain32, fx_mul(d0, n0) - var_p);
		var_e = var_e + fx_mul(gain32, fx_mul(d1, n1) - var_e);
		cov_pe = cov_pe + fx_mul(gain32, fx_mul(d0, n1) - cov_pe);
		det32 = fx_mul(var_p, var_e) - fx_mul(cov_pe, cov_pe);
		det = 64'(signed'(det32));
		// tiny determinants are pushed out to +/-10 LSB
		if (det >= 0 && det < 64'(DET_FLOOR))
			det = 64'(DET_FLOOR);
		if (det < 0 && det > 64'(DET_FLOOR_NEG))
			det = 64'(DET_FLOOR_NEG);
		inv_a = fx_div(var_e, det);
		inv_b = fx_div(32'd0 - cov_pe, det);
		inv_c = fx_div(var_p, det);
	endtask

	task automatic model_reset();
		gain = ALPHA_RESET;
		mu_p = '0; mu_e = '0;
		var_p = Q_ONE; cov_pe = '0; var_e = Q_ONE;
		inv_a = Q_ONE; inv_b = '0; inv_c = Q_ONE;
	endtask

	// idle the input for a while; valid drops only when the gap is real
	task automatic random_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// one item through the input handshake, predicted at acceptance
	task automatic send_item(logic k, logic [31:0] x0, logic [31:0] x1, bit gaps);
		if (gaps)
			random_gap();
		in_valid <= 1'b1;
		kind <= k;
		phase <= x0;
		entropy <= x1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_dist.push_back(mahal_dist(x0, x1));
		if (k == KIND_UPDATE) begin
			learn_sample(x0, x1);
			updates_sent++;
		end
		items_sent++;
	endtask

	task automatic write_gain(logic [16:0] value);
		in_valid <= 1'b0;
		while (expected_dist.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		gain = value;
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
			default: return 32'(signed'($urandom_range(0, 2000)) - 1000);
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_dist.size() == 0) begin
				errors++;
				$display("%0t: unexpected result distance_sq=%h", $time, distance_sq);
			end else begin
				if (distance_sq !== expected_dist[0]) begin
					errors++;
					$display("%0t: distance_sq expected %h actual %h", $time,
						expected_dist[0], distance_sq);
				end
				void'(expected_dist.pop_front());
			end
		end
	end

	// receiver stalls: bursts of random length, with quiet stretches
	always @(posedge clk) begin
		if (out_stall_hold)
			out_stall <= 1'b0;
		else if ($urandom_range(0, 7) == 0)
			out_stall <= 1'b1;
		else if ($urandom_range(0, 3) == 0)
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		stim_row_t table_rows[$];
		logic [16:0] gains[5];
		int mode;
		int seq_len;
		bit paused;

		errors = 0; items_sent = 0; results_seen = 0; updates_sent = 0; cycles = 0;
		paused = 1'b0;
		out_stall_hold = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_wdata = '0;
		in_valid = 1'b0; kind = KIND_SCORE; phase = '0; entropy = '0;
		out_stall = 1'b0;
		model_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the inverse is identity: distance = x0^2 + x1^2
		table_rows = '{
			'{KIND_SCORE, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
			'{KIND_SCORE, 32'h0001_0000, 32'h0000_0000, 1'b1, 32'h0001_0000},
			'{KIND_SCORE, 32'h0001_0000, 32'h0001_0000, 1'b1, 32'h0002_0000},
			'{KIND_SCORE, 32'hFFFF_0000, 32'h0002_0000, 1'b1, 32'h0005_0000},
			'{KIND_SCORE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
			'{KIND_SCORE, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0},
			'{KIND_SCORE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0},
			'{KIND_UPDATE, 32'h0001_0000, 32'h0002_0000, 1'b0, 32'h0},
			'{KIND_UPDATE, 32'h0001_0000, 32'h0002_0000, 1'b0, 32'h0},
			'{KIND_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
			'{KIND_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
			'{KIND_SCORE, 32'h0003_0000, 32'hFFFD_0000, 1'b0, 32'h0},
			'{KIND_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0},
			'{KIND_UPDATE, 32'h0000_0005, 32'h0000_0005, 1'b0, 32'h0},
			'{KIND_UPDATE, 32'h0000_0005, 32'h0000_0005, 1'b0, 32'h0},
			'{KIND_SCORE, 32'h1234_5678, 32'hEDCB_A987, 1'b0, 32'h0}
		};
		foreach (table_rows[i]) begin
			if (table_rows[i].has_known && mahal_dist(table_rows[i].phase,
					table_rows[i].entropy) !== table_rows[i].known) begin
				errors++;
				$display("%0t: row %0d expected %h actual %h", $time, i,
					table_rows[i].known,
					mahal_dist(table_rows[i].phase, table_rows[i].entropy));
			end
			send_item(table_rows[i].kind, table_rows[i].phase, table_rows[i].entropy, 1'b1);
		end

		// gain extremes, including above one; tiny-variance runs hit the det floor
		gains = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768, ALPHA_RESET};
		foreach (gains[g]) begin
			write_gain(gains[g]);
			for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
				mode = $urandom_range(0, 9);
				if (mode < 6) begin
					// clustered samples keep the model sane and reach deep updates
					seq_len = $urandom_range(1, 6);
					for (int j = 0; j < seq_len && i < RANDOM_ITEMS / 5; j++, i++)
						send_item($urandom_range(0, 3) != 0, rand_coord(1), rand_coord(1),
							$urandom_range(0, 4) == 0);
					i--;
				end else if (mode < 8)
					send_item(1'($urandom_range(0, 1)), rand_coord(2), rand_coord(2),
						$urandom_range(0, 1) == 1);
				else
					send_item(1'($urandom_range(0, 1)), rand_coord(0), rand_coord(0), 1'b1);
				if (!paused && i >= 40 && g == 1) begin
					// sender holds off until the block has drained
					paused = 1'b1;
					in_valid <= 1'b0;
					while (expected_dist.size() != 0)
						@(posedge clk);
				end
			end
		end

		in_valid <= 1'b0;
		out_stall_hold = 1'b1;
		while (expected_dist.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d items (%0d model updates), %0d results checked,",
			items_sent, updates_sent, results_seen);
		$display("over five gain settings from zero to the 17-bit maximum.");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
